FILE: design/riot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riot_pkg
// Shared types, field widths and codes for the RIOT ports, timer and edge irq.
// ----------------------------------------------------------------------------
package riot_pkg;

    localparam int OP_W       = 3;
    localparam int ADDR_W     = 5;
    localparam int BYTE_W     = 8;
    localparam int DELTA_W    = 20;
    localparam int SHIFT_W    = 4;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 16;

    localparam logic [DELTA_W-1:0] DELTA_SIGN = 20'h80000;
    localparam logic [DELTA_W-1:0] DELTA_ALL  = 20'hFFFFF;
    localparam logic [BYTE_W-1:0]  FLAG_TIMER = 8'h80;
    localparam logic [BYTE_W-1:0]  FLAG_EDGE  = 8'h40;

    typedef enum logic [OP_W-1:0] {
        OP_TICK  = 3'd0,
        OP_READ  = 3'd1,
        OP_WRITE = 3'd2,
        OP_PINS_A = 3'd3,
        OP_PINS_B = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        RD_PORT_A  = 3'd0,
        RD_DIR_A   = 3'd1,
        RD_PORT_B  = 3'd2,
        RD_DIR_B   = 3'd3,
        RD_TIMER   = 3'd4,
        RD_FLAGS   = 3'd5,
        RD_TIMER_2 = 3'd6,
        RD_FLAGS_2 = 3'd7
    } t_rd_sel;

    typedef enum logic [1:0] {
        WR_OUT_A = 2'd0,
        WR_DIR_A = 2'd1,
        WR_OUT_B = 2'd2,
        WR_DIR_B = 2'd3
    } t_wr_sel;

    // prescale 1, 8, 64, 1024
    function automatic logic [SHIFT_W-1:0] prescale_shift(input logic [1:0] sel);
        logic [SHIFT_W-1:0] s;
        case (sel)
            2'd0:    s = 4'd0;
            2'd1:    s = 4'd3;
            2'd2:    s = 4'd6;
            default: s = 4'd10;
        endcase
        return s;
    endfunction

endpackage

FILE: design/riot_ports_timer_edge_irq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riot_ports_timer_edge_irq
// RIOT-style peripheral: two 8-bit ports, PA7 edge detector, interval timer
// with prescale and two irq flags, driven by one word per clock.
// ----------------------------------------------------------------------------
// output: the result word is registered in the output register on the accepting edge
// throughput: one word per cycle, state updated on the accepting edge
// input is taken while the result register is empty or being drained
// reset: synchronous active low, clears ports, flags and enables, timer
// disarmed with delta all ones, output register empty
// ----------------------------------------------------------------------------
module riot_ports_timer_edge_irq (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // op[2:0], addr[7:3], data[15:8], pin_mask[23:16]
    input  logic [riot_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // read_data[7:0], irq[8], zero fill above
    output logic [riot_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import riot_pkg::*;

    logic [OP_W-1:0]    in_op;
    logic [ADDR_W-1:0]  in_addr;
    logic [BYTE_W-1:0]  in_data;
    logic [BYTE_W-1:0]  in_mask;
    logic               s_accept;

    logic [BYTE_W-1:0]  r_a_out, n_a_out, r_a_dir, n_a_dir;
    logic [BYTE_W-1:0]  r_b_out, n_b_out, r_b_dir, n_b_dir;
    logic [BYTE_W-1:0]  r_pins_a, n_pins_a, r_pins_b, n_pins_b;
    logic               r_edge_rising, n_edge_rising;
    logic               r_edge_en, n_edge_en, r_edge_flag, n_edge_flag;
    logic               r_timer_en, n_timer_en, r_timer_flag, n_timer_flag;
    logic               r_timer_armed, n_timer_armed;
    logic [SHIFT_W-1:0] r_shift, n_shift;
    logic [DELTA_W-1:0] r_delta, n_delta;

    logic               r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data;

    logic [DELTA_W-1:0] tick_delta;
    logic [DELTA_W-1:0] shifted;
    logic [8:0]         count;
    logic [SHIFT_W-1:0] wr_shift;
    logic [DELTA_W-1:0] load_delta;
    logic [BYTE_W-1:0]  pa_new;
    logic               timer_neg;
    logic [BYTE_W-1:0]  rd;
    logic               irq;

    assign in_op   = s_axis_tdata[2:0];
    assign in_addr = s_axis_tdata[7:3];
    assign in_data = s_axis_tdata[15:8];
    assign in_mask = s_axis_tdata[23:16];

    assign s_axis_tready = !r_m_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    assign timer_neg  = r_delta[DELTA_W-1];
    assign tick_delta = (r_delta == DELTA_SIGN) ? (DELTA_SIGN + DELTA_W'(8'hFF))
                                                : (r_delta - DELTA_W'(1));
    assign shifted    = r_delta >> r_shift;
    assign count      = (in_data == '0) ? 9'd256 : {1'b0, in_data};
    assign wr_shift   = prescale_shift(in_addr[1:0]);
    assign load_delta = (DELTA_W'(count) << wr_shift) + DELTA_W'(1);
    assign pa_new     = ((r_pins_a ^ in_data) & in_mask) ^ r_pins_a;

    always_comb begin
        n_a_out       = r_a_out;
        n_a_dir       = r_a_dir;
        n_b_out       = r_b_out;
        n_b_dir       = r_b_dir;
        n_pins_a      = r_pins_a;
        n_pins_b      = r_pins_b;
        n_edge_rising = r_edge_rising;
        n_edge_en     = r_edge_en;
        n_edge_flag   = r_edge_flag;
        n_timer_en    = r_timer_en;
        n_timer_flag  = r_timer_flag;
        n_timer_armed = r_timer_armed;
        n_shift       = r_shift;
        n_delta       = r_delta;
        rd            = '0;
        case (in_op)
            OP_TICK: begin
                n_delta = tick_delta;
                if (r_timer_armed && !r_timer_flag &&
                    (tick_delta == '0 ||
                     (tick_delta[DELTA_W-1] && tick_delta[7:0] == '0))) begin
                    n_timer_flag  = 1'b1;
                    n_timer_armed = 1'b0;
                end
            end
            OP_READ: begin
                case (in_addr[2:0])
                    RD_PORT_A: rd = (r_a_out | ~r_a_dir) & r_pins_a;
                    RD_DIR_A:  rd = r_a_dir;
                    RD_PORT_B: rd = ((r_pins_b ^ r_b_out) & r_b_dir) ^ r_pins_b;
                    RD_DIR_B:  rd = r_b_dir;
                    RD_TIMER, RD_TIMER_2: begin
                        if (r_timer_flag && timer_neg && r_delta[7:0] != '0) begin
                            n_timer_flag  = 1'b0;
                            n_timer_armed = 1'b1;
                        end
                        n_timer_en = in_addr[3];
                        rd = timer_neg ? r_delta[7:0] : shifted[7:0];
                    end
                    default: begin
                        rd = (r_timer_flag ? FLAG_TIMER : '0) |
                             (r_edge_flag ? FLAG_EDGE : '0);
                        n_edge_flag = 1'b0;
                    end
                endcase
            end
            OP_WRITE: begin
                if (in_addr[2]) begin
                    if (in_addr[4]) begin
                        n_shift       = wr_shift;
                        n_delta       = load_delta;
                        n_timer_en    = in_addr[3];
                        n_timer_flag  = 1'b0;
                        n_timer_armed = 1'b1;
                    end else begin
                        n_edge_rising = in_addr[0];
                        n_edge_en     = in_addr[1];
                    end
                end else begin
                    case (in_addr[1:0])
                        WR_OUT_A: n_a_out = in_data;
                        WR_DIR_A: n_a_dir = in_data;
                        WR_OUT_B: n_b_out = in_data;
                        default:  n_b_dir = in_data;
                    endcase
                end
            end
            OP_PINS_A: begin
                n_pins_a = pa_new;
                if ((r_pins_a[7] != pa_new[7]) && (pa_new[7] == r_edge_rising) &&
                    (!r_a_dir[7] || r_a_out[7])) begin
                    n_edge_flag = 1'b1;
                end
            end
            OP_PINS_B: n_pins_b = ((r_pins_b ^ in_data) & in_mask) ^ r_pins_b;
            default: ;
        endcase
        irq = (n_timer_flag && n_timer_en) || (n_edge_flag && n_edge_en);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_out       <= '0;
            r_a_dir       <= '0;
            r_b_out       <= '0;
            r_b_dir       <= '0;
            r_pins_a      <= '0;
            r_pins_b      <= '0;
            r_edge_rising <= 1'b0;
            r_edge_en     <= 1'b0;
            r_edge_flag   <= 1'b0;
            r_timer_en    <= 1'b0;
            r_timer_flag  <= 1'b0;
            r_timer_armed <= 1'b0;
            r_shift       <= '0;
            r_delta       <= DELTA_ALL;
            r_m_valid     <= 1'b0;
        end else begin
            if (s_accept) begin
                r_a_out       <= n_a_out;
                r_a_dir       <= n_a_dir;
                r_b_out       <= n_b_out;
                r_b_dir       <= n_b_dir;
                r_pins_a      <= n_pins_a;
                r_pins_b      <= n_pins_b;
                r_edge_rising <= n_edge_rising;
                r_edge_en     <= n_edge_en;
                r_edge_flag   <= n_edge_flag;
                r_timer_en    <= n_timer_en;
                r_timer_flag  <= n_timer_flag;
                r_timer_armed <= n_timer_armed;
                r_shift       <= n_shift;
                r_delta       <= n_delta;
                r_m_valid     <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid     <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_m_data <= {{(OUT_TDATA_W-BYTE_W-1){1'b0}}, irq, rd};
        end
    end

    a_flag_not_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_timer_flag && r_timer_armed))
        else $error("timer flag raised while still armed");

    a_zero_unless_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && in_op != OP_READ |=> r_m_data[BYTE_W-1:0] == '0)
        else $error("read data nonzero for a non-read word");

    a_timer_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept && in_op == OP_WRITE && in_addr[2] && in_addr[4]
        |=> r_timer_armed && !r_timer_flag && !r_delta[DELTA_W-1])
        else $error("timer write did not arm the timer");

    a_irq_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> r_m_data[BYTE_W] ==
            ((r_timer_flag && r_timer_en) || (r_edge_flag && r_edge_en)))
        else $error("irq bit disagrees with flags and enables");

    a_shift_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_shift == 4'd0 || r_shift == 4'd3 || r_shift == 4'd6 || r_shift == 4'd10)
        else $error("illegal prescale shift");

endmodule
